// ===== rtl/lfuc_pkg.sv =====
`timescale 1ns / 1ps

package lfuc_pkg;

    // Default sizing handed to the top level
    localparam int DEF_ENTRIES    = 16;
    localparam int DEF_KEY_BITS   = 32;
    localparam int DEF_COUNT_BITS = 16;

    // Fixed field widths of the stream and configuration ports
    localparam int KEY_IN_BITS    = 32;
    localparam int DATA_BITS      = 32;
    localparam int IN_TDATA_BITS  = 64;
    localparam int OUT_TDATA_BITS = 32;
    localparam int CAP_BITS       = 5;
    localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

    // Entries scanned per group in the first half of the victim search
    localparam int GROUP_SIZE = 8;

    typedef enum logic {
        OP_GET = 1'b0,
        OP_PUT = 1'b1
    } t_opcode;

    // Request summary produced by the lookup stage
    typedef struct packed {
        logic is_put;
        logic hit;
        logic cap_zero;
        logic evict;
        logic have_free;
    } t_sel_flags;

    function automatic int f_idx_bits(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

    function automatic int f_groups(input int n);
        return (n + GROUP_SIZE - 1) / GROUP_SIZE;
    endfunction

endpackage

// ===== rtl/lfuc_select.sv =====
`timescale 1ns / 1ps

// Lookup stage: key match, free slot, capacity check and per-group victim minima.
module lfuc_select
    import lfuc_pkg::*;
#(
    parameter int ENTRIES    = DEF_ENTRIES,
    parameter int KEY_BITS   = DEF_KEY_BITS,
    parameter int COUNT_BITS = DEF_COUNT_BITS,
    localparam int IDX_BITS  = f_idx_bits(ENTRIES),
    localparam int OCC_BITS  = $clog2(ENTRIES + 1),
    localparam int NGROUPS   = f_groups(ENTRIES)
) (
    input  logic                  i_clk,
    input  logic                  i_load,
    input  t_opcode               i_op,
    input  logic [KEY_BITS-1:0]   i_key,
    input  logic [DATA_BITS-1:0]  i_wval,
    input  logic [CAP_BITS-1:0]   i_cap,
    input  logic                  i_ent_valid [ENTRIES],
    input  logic [KEY_BITS-1:0]   i_ent_key   [ENTRIES],
    input  logic [DATA_BITS-1:0]  i_ent_value [ENTRIES],
    input  logic [COUNT_BITS-1:0] i_ent_count [ENTRIES],
    input  logic [IDX_BITS-1:0]   i_ent_rank  [ENTRIES],
    input  logic [OCC_BITS-1:0]   i_occ,
    output t_sel_flags            o_flags,
    output logic [IDX_BITS-1:0]   o_hit_idx,
    output logic [IDX_BITS-1:0]   o_hit_rank,
    output logic [DATA_BITS-1:0]  o_hit_value,
    output logic [IDX_BITS-1:0]   o_free_idx,
    output logic                  o_grp_valid [NGROUPS],
    output logic [IDX_BITS-1:0]   o_grp_idx   [NGROUPS],
    output logic [COUNT_BITS-1:0] o_grp_count [NGROUPS],
    output logic [IDX_BITS-1:0]   o_grp_rank  [NGROUPS],
    output logic [KEY_BITS-1:0]   o_key,
    output logic [DATA_BITS-1:0]  o_wval
);

    localparam int CMP_BITS = (OCC_BITS > CAP_BITS) ? OCC_BITS : CAP_BITS;

    t_sel_flags            n_flags;
    logic [IDX_BITS-1:0]   n_hit_idx;
    logic [IDX_BITS-1:0]   n_hit_rank;
    logic [DATA_BITS-1:0]  n_hit_value;
    logic [IDX_BITS-1:0]   n_free_idx;
    logic                  n_grp_valid [NGROUPS];
    logic [IDX_BITS-1:0]   n_grp_idx   [NGROUPS];
    logic [COUNT_BITS-1:0] n_grp_count [NGROUPS];
    logic [IDX_BITS-1:0]   n_grp_rank  [NGROUPS];
    logic [CMP_BITS-1:0]   w_cap_ext;
    logic [CMP_BITS-1:0]   w_cap_eff;

    // Capacity clamped to the number of entries
    assign w_cap_ext = CMP_BITS'(i_cap);
    assign w_cap_eff = (w_cap_ext > CMP_BITS'(ENTRIES)) ? CMP_BITS'(ENTRIES) : w_cap_ext;

    // Match and free slot; keys are unique among valid entries, so the match is one-hot
    always_comb begin
        n_flags.hit       = 1'b0;
        n_flags.have_free = 1'b0;
        n_hit_idx         = '0;
        n_hit_rank        = '0;
        n_hit_value       = '0;
        n_free_idx        = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (i_ent_valid[i] && (i_ent_key[i] == i_key)) begin
                n_flags.hit = 1'b1;
                n_hit_idx   = n_hit_idx | IDX_BITS'(i);
                n_hit_rank  = n_hit_rank | i_ent_rank[i];
                n_hit_value = n_hit_value | i_ent_value[i];
            end
        end
        // lowest-numbered free slot wins
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!i_ent_valid[i]) begin
                n_flags.have_free = 1'b1;
                n_free_idx        = IDX_BITS'(i);
            end
        end
        n_flags.is_put   = (i_op == OP_PUT);
        n_flags.cap_zero = (w_cap_eff == '0);
        n_flags.evict    = (CMP_BITS'(i_occ) >= w_cap_eff);
    end

    // Per-group minimum: lowest count, then oldest (highest rank)
    always_comb begin
        int e;
        for (int g = 0; g < NGROUPS; g++) begin
            n_grp_valid[g] = 1'b0;
            n_grp_idx[g]   = '0;
            n_grp_count[g] = '0;
            n_grp_rank[g]  = '0;
            for (int k = 0; k < GROUP_SIZE; k++) begin
                e = g * GROUP_SIZE + k;
                if (e < ENTRIES) begin
                    if (i_ent_valid[e] &&
                        (!n_grp_valid[g] || (i_ent_count[e] < n_grp_count[g]) ||
                         ((i_ent_count[e] == n_grp_count[g]) &&
                          (i_ent_rank[e] > n_grp_rank[g])))) begin
                        n_grp_valid[g] = 1'b1;
                        n_grp_idx[g]   = IDX_BITS'(e);
                        n_grp_count[g] = i_ent_count[e];
                        n_grp_rank[g]  = i_ent_rank[e];
                    end
                end
            end
        end
    end

    // Stage register
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            o_flags     <= n_flags;
            o_hit_idx   <= n_hit_idx;
            o_hit_rank  <= n_hit_rank;
            o_hit_value <= n_hit_value;
            o_free_idx  <= n_free_idx;
            o_grp_valid <= n_grp_valid;
            o_grp_idx   <= n_grp_idx;
            o_grp_count <= n_grp_count;
            o_grp_rank  <= n_grp_rank;
            o_key       <= i_key;
            o_wval      <= i_wval;
        end
    end

endmodule

// ===== rtl/lfuc_store.sv =====
`timescale 1ns / 1ps

// Entry storage plus commit stage: final victim pick, count and rank updates.
module lfuc_store
    import lfuc_pkg::*;
#(
    parameter int ENTRIES    = DEF_ENTRIES,
    parameter int KEY_BITS   = DEF_KEY_BITS,
    parameter int COUNT_BITS = DEF_COUNT_BITS,
    localparam int IDX_BITS  = f_idx_bits(ENTRIES),
    localparam int OCC_BITS  = $clog2(ENTRIES + 1),
    localparam int NGROUPS   = f_groups(ENTRIES)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_commit,
    input  t_sel_flags            i_flags,
    input  logic [IDX_BITS-1:0]   i_hit_idx,
    input  logic [IDX_BITS-1:0]   i_hit_rank,
    input  logic [DATA_BITS-1:0]  i_hit_value,
    input  logic [IDX_BITS-1:0]   i_free_idx,
    input  logic                  i_grp_valid [NGROUPS],
    input  logic [IDX_BITS-1:0]   i_grp_idx   [NGROUPS],
    input  logic [COUNT_BITS-1:0] i_grp_count [NGROUPS],
    input  logic [IDX_BITS-1:0]   i_grp_rank  [NGROUPS],
    input  logic [KEY_BITS-1:0]   i_key,
    input  logic [DATA_BITS-1:0]  i_wval,
    output logic                  o_ent_valid [ENTRIES],
    output logic [KEY_BITS-1:0]   o_ent_key   [ENTRIES],
    output logic [DATA_BITS-1:0]  o_ent_value [ENTRIES],
    output logic [COUNT_BITS-1:0] o_ent_count [ENTRIES],
    output logic [IDX_BITS-1:0]   o_ent_rank  [ENTRIES],
    output logic [OCC_BITS-1:0]   o_occ,
    output logic                  o_hit,
    output logic [DATA_BITS-1:0]  o_read_value
);

    logic                  r_valid [ENTRIES];
    logic [KEY_BITS-1:0]   r_key   [ENTRIES];
    logic [DATA_BITS-1:0]  r_value [ENTRIES];
    logic [COUNT_BITS-1:0] r_count [ENTRIES];
    logic [IDX_BITS-1:0]   r_rank  [ENTRIES];
    logic [OCC_BITS-1:0]   r_occ;

    logic                  w_v_found;
    logic [IDX_BITS-1:0]   w_v_idx;
    logic [COUNT_BITS-1:0] w_v_count;
    logic [IDX_BITS-1:0]   w_v_rank;
    logic                  w_do_touch;
    logic                  w_do_insert;
    logic                  w_use_victim;
    logic                  w_age_all;
    logic [IDX_BITS-1:0]   w_slot;
    logic [IDX_BITS-1:0]   w_promote;
    logic [IDX_BITS-1:0]   w_thr;
    logic                  w_age [ENTRIES];

    // Victim across the group minima
    always_comb begin
        w_v_found = 1'b0;
        w_v_idx   = '0;
        w_v_count = '0;
        w_v_rank  = '0;
        for (int g = 0; g < NGROUPS; g++) begin
            if (i_grp_valid[g] &&
                (!w_v_found || (i_grp_count[g] < w_v_count) ||
                 ((i_grp_count[g] == w_v_count) && (i_grp_rank[g] > w_v_rank)))) begin
                w_v_found = 1'b1;
                w_v_idx   = i_grp_idx[g];
                w_v_count = i_grp_count[g];
                w_v_rank  = i_grp_rank[g];
            end
        end
    end

    // Request decode; a freed victim slot competes with free slots by index
    assign w_do_touch   = i_flags.hit && (!i_flags.is_put || !i_flags.cap_zero);
    assign w_do_insert  = i_flags.is_put && !i_flags.hit && !i_flags.cap_zero;
    assign w_use_victim = w_do_insert && i_flags.evict && w_v_found;
    assign w_age_all    = w_do_insert && !w_use_victim;
    assign w_slot       = (w_use_victim && (!i_flags.have_free || (w_v_idx < i_free_idx)))
                          ? w_v_idx : i_free_idx;
    assign w_promote    = w_do_touch ? i_hit_idx : w_v_idx;
    assign w_thr        = w_do_touch ? i_hit_rank : w_v_rank;

    // Entries more recent than the promoted or evicted one age by one; a non-evicting insert ages all
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            w_age[i] = r_valid[i] && (w_do_touch || w_do_insert) &&
                       (w_age_all || ((IDX_BITS'(i) != w_promote) && (r_rank[i] < w_thr)));
        end
    end

    // Valid bits and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                r_valid[i] <= 1'b0;
            end
            r_occ <= '0;
        end else if (i_commit && w_do_insert) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (IDX_BITS'(i) == w_slot) begin
                    r_valid[i] <= 1'b1;
                end else if (w_use_victim && (IDX_BITS'(i) == w_v_idx)) begin
                    r_valid[i] <= 1'b0;
                end
            end
            if (!w_use_victim) begin
                r_occ <= r_occ + OCC_BITS'(1);
            end
        end
    end

    // Entry payload: insert, touch, or age
    always_ff @(posedge i_clk) begin
        if (i_commit) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (w_do_insert && (IDX_BITS'(i) == w_slot)) begin
                    r_key[i]   <= i_key;
                    r_value[i] <= i_wval;
                    r_count[i] <= COUNT_BITS'(1);
                    r_rank[i]  <= '0;
                end else if (w_do_touch && (IDX_BITS'(i) == i_hit_idx)) begin
                    if (i_flags.is_put) begin
                        r_value[i] <= i_wval;
                    end
                    if (r_count[i] != '1) begin
                        r_count[i] <= r_count[i] + COUNT_BITS'(1);
                    end
                    r_rank[i] <= '0;
                end else if (w_age[i]) begin
                    r_rank[i] <= r_rank[i] + IDX_BITS'(1);
                end
            end
        end
    end

    assign o_ent_valid  = r_valid;
    assign o_ent_key    = r_key;
    assign o_ent_value  = r_value;
    assign o_ent_count  = r_count;
    assign o_ent_rank   = r_rank;
    assign o_occ        = r_occ;
    assign o_hit        = i_flags.hit;
    assign o_read_value = (i_flags.hit && !i_flags.is_put) ? i_hit_value : '0;

endmodule

// ===== rtl/lfu_cache_lru_tiebreak_top.sv =====
`timescale 1ns / 1ps

// Fully associative key/value cache with least-frequently-used replacement and
// least-recently-used tie-break. Each request (tuser: get = 0, put = 1) is
// answered with exactly one response whose tuser is the hit flag and whose tdata
// is the stored value on a get hit, else zero. A request passes the request register,
// the lookup stage (key match, free slot, per-group victim minima) and the commit
// stage (final victim pick, count and rank update), which waits for room in the
// response register; a new request is taken in the same cycle the previous one
// commits. Use counts saturate. The capacity register may be written only while no
// request is in flight; zero disables puts, values above the entry count act as the
// entry count. No clearing pass is needed after reset.
module lfu_cache_lru_tiebreak_top
    import lfuc_pkg::*;
#(
    parameter int ENTRIES    = DEF_ENTRIES,
    parameter int KEY_BITS   = DEF_KEY_BITS,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // request stream
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  logic [IN_TDATA_BITS-1:0]  i_s_axis_tdata,  // key[31:0], write_value[63:32]
    input  logic                      i_s_axis_tuser,  // opcode[0]
    // response stream
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    output logic [OUT_TDATA_BITS-1:0] o_m_axis_tdata,  // read_value[31:0]
    output logic                      o_m_axis_tuser,  // hit[0]
    // capacity register write
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CAP_BITS-1:0]       i_cfg_data
);

    localparam int IDX_BITS = f_idx_bits(ENTRIES);
    localparam int OCC_BITS = $clog2(ENTRIES + 1);
    localparam int NGROUPS  = f_groups(ENTRIES);

    logic [CAP_BITS-1:0]   r_cap;
    logic                  r_in_valid;
    t_opcode               r_in_op;
    logic [KEY_BITS-1:0]   r_in_key;
    logic [DATA_BITS-1:0]  r_in_wval;
    logic                  r_mid_valid;
    logic                  r_out_valid;
    logic                  r_out_hit;
    logic [DATA_BITS-1:0]  r_out_value;

    logic                  w_accept;
    logic                  w_load;
    logic                  w_done;

    t_sel_flags            w_flags;
    logic [IDX_BITS-1:0]   w_hit_idx;
    logic [IDX_BITS-1:0]   w_hit_rank;
    logic [DATA_BITS-1:0]  w_hit_value;
    logic [IDX_BITS-1:0]   w_free_idx;
    logic                  w_grp_valid [NGROUPS];
    logic [IDX_BITS-1:0]   w_grp_idx   [NGROUPS];
    logic [COUNT_BITS-1:0] w_grp_count [NGROUPS];
    logic [IDX_BITS-1:0]   w_grp_rank  [NGROUPS];
    logic [KEY_BITS-1:0]   w_mid_key;
    logic [DATA_BITS-1:0]  w_mid_wval;
    logic                  w_ent_valid [ENTRIES];
    logic [KEY_BITS-1:0]   w_ent_key   [ENTRIES];
    logic [DATA_BITS-1:0]  w_ent_value [ENTRIES];
    logic [COUNT_BITS-1:0] w_ent_count [ENTRIES];
    logic [IDX_BITS-1:0]   w_ent_rank  [ENTRIES];
    logic [OCC_BITS-1:0]   w_occ;
    logic                  w_hit;
    logic [DATA_BITS-1:0]  w_read_value;

    // Handshake: commit needs room in the response register; nothing taken in reset
    assign w_done          = r_mid_valid && (!r_out_valid || i_m_axis_tready);
    assign w_load          = r_in_valid && !r_mid_valid;
    assign o_s_axis_tready = i_rst_n && !r_in_valid && (!r_mid_valid || w_done);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = i_rst_n;

    // Capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_valid) begin
            r_cap <= i_cfg_data;
        end
    end

    // Pipeline occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_mid_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_load) begin
                r_in_valid <= 1'b0;
            end
            if (w_load) begin
                r_mid_valid <= 1'b1;
            end else if (w_done) begin
                r_mid_valid <= 1'b0;
            end
            if (w_done) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request register
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_op   <= t_opcode'(i_s_axis_tuser);
            r_in_key  <= KEY_BITS'(i_s_axis_tdata[KEY_IN_BITS-1:0]);
            r_in_wval <= i_s_axis_tdata[IN_TDATA_BITS-1:KEY_IN_BITS];
        end
    end

    // Response register
    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out_hit   <= w_hit;
            r_out_value <= w_read_value;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_value;
    assign o_m_axis_tuser  = r_out_hit;

    lfuc_select #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_select (
        .i_clk       (i_clk),
        .i_load      (w_load),
        .i_op        (r_in_op),
        .i_key       (r_in_key),
        .i_wval      (r_in_wval),
        .i_cap       (r_cap),
        .i_ent_valid (w_ent_valid),
        .i_ent_key   (w_ent_key),
        .i_ent_value (w_ent_value),
        .i_ent_count (w_ent_count),
        .i_ent_rank  (w_ent_rank),
        .i_occ       (w_occ),
        .o_flags     (w_flags),
        .o_hit_idx   (w_hit_idx),
        .o_hit_rank  (w_hit_rank),
        .o_hit_value (w_hit_value),
        .o_free_idx  (w_free_idx),
        .o_grp_valid (w_grp_valid),
        .o_grp_idx   (w_grp_idx),
        .o_grp_count (w_grp_count),
        .o_grp_rank  (w_grp_rank),
        .o_key       (w_mid_key),
        .o_wval      (w_mid_wval)
    );

    lfuc_store #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_store (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_commit     (w_done),
        .i_flags      (w_flags),
        .i_hit_idx    (w_hit_idx),
        .i_hit_rank   (w_hit_rank),
        .i_hit_value  (w_hit_value),
        .i_free_idx   (w_free_idx),
        .i_grp_valid  (w_grp_valid),
        .i_grp_idx    (w_grp_idx),
        .i_grp_count  (w_grp_count),
        .i_grp_rank   (w_grp_rank),
        .i_key        (w_mid_key),
        .i_wval       (w_mid_wval),
        .o_ent_valid  (w_ent_valid),
        .o_ent_key    (w_ent_key),
        .o_ent_value  (w_ent_value),
        .o_ent_count  (w_ent_count),
        .o_ent_rank   (w_ent_rank),
        .o_occ        (w_occ),
        .o_hit        (w_hit),
        .o_read_value (w_read_value)
    );

endmodule

// ===== dv/lfu_cache_lru_tiebreak_top_tb.sv =====
`timescale 1ns / 1ps

module lfu_cache_lru_tiebreak_top_tb;
    import lfuc_pkg::*;

    localparam int N_ENTRIES   = DEF_ENTRIES;
    localparam int POOL_SIZE   = 24;
    localparam int SEG_ITEMS   = 60;
    localparam int QUIET_LIMIT = 5000;
    localparam int SETTLE_CYC  = 20;
    localparam int MAX_REPORTS = 40;
    localparam logic [DEF_COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef struct {
        logic                 hit;
        logic [DATA_BITS-1:0] read_value;
    } t_response;

    // Cache state mirror plus the queue of responses it predicts
    class lfu_scoreboard;
        bit                        occupied[N_ENTRIES];
        logic [KEY_IN_BITS-1:0]    tag[N_ENTRIES];
        logic [DATA_BITS-1:0]      payload[N_ENTRIES];
        logic [DEF_COUNT_BITS-1:0] uses[N_ENTRIES];
        int unsigned               age[N_ENTRIES];
        int unsigned               fill;
        int unsigned               capacity;
        t_response                 expected_q[$];
        int                        errors;
        int                        requests;
        int                        hits;
        int                        evictions;
        int                        saturated;

        function new();
            capacity = CAP_RESET;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function void set_capacity(logic [CAP_BITS-1:0] v);
            capacity = v;
        endfunction

        // Most recent entry has age 0; younger entries shift back by one
        function void promote(int e);
            int unsigned r;
            r = age[e];
            for (int i = 0; i < N_ENTRIES; i++)
                if (occupied[i] && i != e && age[i] < r) age[i]++;
            age[e] = 0;
        endfunction

        function void bump(int e);
            if (uses[e] != COUNT_MAX) uses[e]++;
            else saturated++;
            promote(e);
        endfunction

        // Lowest count loses, oldest among equal counts
        function void evict_one();
            int victim;
            victim = -1;
            for (int i = 0; i < N_ENTRIES; i++) begin
                if (!occupied[i]) continue;
                if (victim < 0 || uses[i] < uses[victim] ||
                    (uses[i] == uses[victim] && age[i] > age[victim]))
                    victim = i;
            end
            if (victim < 0) return;
            occupied[victim] = 1'b0;
            for (int i = 0; i < N_ENTRIES; i++)
                if (occupied[i] && age[i] > age[victim]) age[i]--;
            if (fill > 0) fill--;
            evictions++;
        endfunction

        function void note_request(t_opcode op, logic [KEY_IN_BITS-1:0] key,
                                   logic [DATA_BITS-1:0] wval);
            int          found;
            int          slot;
            int unsigned limit;
            t_response   exp;
            found = -1;
            limit = (capacity > N_ENTRIES) ? N_ENTRIES : capacity;
            for (int i = 0; i < N_ENTRIES; i++)
                if (found < 0 && occupied[i] && tag[i] == key) found = i;
            exp.hit        = (found >= 0);
            exp.read_value = '0;
            requests++;
            if (found >= 0) hits++;
            if (op == OP_GET) begin
                if (found >= 0) begin
                    exp.read_value = payload[found];
                    bump(found);
                end
            end else if (limit != 0) begin
                if (found >= 0) begin
                    payload[found] = wval;
                    bump(found);
                end else begin
                    if (fill >= limit) evict_one();
                    slot = -1;
                    for (int i = 0; i < N_ENTRIES; i++)
                        if (slot < 0 && !occupied[i]) slot = i;
                    if (slot >= 0) begin
                        for (int i = 0; i < N_ENTRIES; i++)
                            if (occupied[i]) age[i]++;
                        occupied[slot] = 1'b1;
                        tag[slot]      = key;
                        payload[slot]  = wval;
                        uses[slot]     = 1;
                        age[slot]      = 0;
                        fill++;
                    end
                end
            end
            expected_q.push_back(exp);
        endfunction

        function void report(string field, logic [DATA_BITS-1:0] want,
                             logic [DATA_BITS-1:0] got);
            errors++;
            if (errors <= MAX_REPORTS)
                $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
        endfunction

        function void check_response(logic hit, logic [DATA_BITS-1:0] val);
            t_response exp;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $error("response with no request outstanding: hit %0b value 0x%0h",
                           hit, val);
                return;
            end
            exp = expected_q.pop_front();
            if (hit !== exp.hit) report("hit", exp.hit, hit);
            if (val !== exp.read_value) report("read_value", exp.read_value, val);
        endfunction
    endclass

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_s_axis_tvalid = 1'b0;
    logic                      o_s_axis_tready;
    logic [IN_TDATA_BITS-1:0]  i_s_axis_tdata = '0;  // key[31:0], write_value[63:32]
    logic                      i_s_axis_tuser = 1'b0; // opcode[0]
    logic                      o_m_axis_tvalid;
    logic                      i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_BITS-1:0] o_m_axis_tdata;       // read_value[31:0]
    logic                      o_m_axis_tuser;       // hit[0]
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [CAP_BITS-1:0]       i_cfg_data = '0;

    lfu_scoreboard          cache_model;
    int                     send_idle_pct = 26;
    int                     recv_idle_pct = 79;
    int                     quiet_cycles = 0;
    logic [KEY_IN_BITS-1:0] key_pool[POOL_SIZE];

    lfu_cache_lru_tiebreak_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Response side backpressure
    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Response check
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            cache_model.check_response(o_m_axis_tuser, o_m_axis_tdata);
    end

    // Watchdog: no handshake of any kind for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("lfu_cache_lru_tiebreak_top_tb: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // One request, with an optional random gap in front of it
    task automatic send_request(t_opcode op, logic [KEY_IN_BITS-1:0] key,
                                logic [DATA_BITS-1:0] wval);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {wval, key};
        i_s_axis_tuser  <= op;
        do @(posedge i_clk); while (!o_s_axis_tready);
        cache_model.note_request(op, key, wval);
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (cache_model.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_capacity(logic [CAP_BITS-1:0] v);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        cache_model.set_capacity(v);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly keys from a small, slowly changing pool so hits and evictions occur
    task automatic run_random(int count, int cap_eff);
        int                     span;
        t_opcode                op;
        logic [KEY_IN_BITS-1:0] key;
        span = (cap_eff == 0) ? 6 : cap_eff + 4;
        if (span > POOL_SIZE) span = POOL_SIZE;
        repeat (count) begin
            if ($urandom_range(9) == 0) key_pool[$urandom_range(POOL_SIZE - 1)] = $urandom();
            op = t_opcode'($urandom_range(1));
            if ($urandom_range(99) < 85) key = key_pool[$urandom_range(span - 1)];
            else key = $urandom();
            send_request(op, key, $urandom());
        end
    endtask

    logic [CAP_BITS-1:0] seg_cap[8] = '{5'd31, 5'd5, 5'd2, 5'd0, 5'd17, 5'd1, 5'd9, 5'd16};

    initial begin
        cache_model = new();
        foreach (key_pool[i]) key_pool[i] = $urandom();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Field extremes, overwrite, hits and misses at reset capacity
        send_request(OP_GET, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(OP_GET, 32'h0000_0000, 32'h0000_0000);
        send_request(OP_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(OP_PUT, 32'h0000_0000, 32'h1234_5678);
        send_request(OP_GET, 32'h0000_0000, 32'h0000_0000);

        // Capacity zero: puts change nothing, gets still hit
        write_capacity(5'd0);
        send_request(OP_PUT, 32'h0000_0000, 32'hAAAA_AAAA);
        send_request(OP_PUT, 32'h0000_00A5, 32'h5555_5555);
        send_request(OP_GET, 32'h0000_0000, 32'h0000_0000);
        send_request(OP_GET, 32'h0000_00A5, 32'h0000_0000);

        // Capacity below occupancy: one victim, slot reused
        write_capacity(5'd1);
        send_request(OP_PUT, 32'h5A5A_5A5A, 32'h0000_0001);
        send_request(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(OP_GET, 32'h5A5A_5A5A, 32'h0000_0000);
        send_request(OP_GET, 32'h0000_0000, 32'h0000_0000);

        // Capacity above entry count, then a tie on count broken by age
        write_capacity(5'd31);
        send_request(OP_PUT, 32'hC1C1_C1C1, 32'h0000_00C1);
        send_request(OP_PUT, 32'hC2C2_C2C2, 32'h0000_00C2);
        write_capacity(5'd3);
        send_request(OP_PUT, 32'hC3C3_C3C3, 32'h0000_00C3);
        send_request(OP_GET, 32'hC1C1_C1C1, 32'h0000_0000);
        send_request(OP_GET, 32'hC2C2_C2C2, 32'h0000_0000);

        // Random traffic over several capacities and idle patterns
        for (int seg = 0; seg < 8; seg++) begin
            if (seg == 3) begin
                send_idle_pct = 79;
                recv_idle_pct = 26;
            end else if (seg == 6) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_capacity(seg_cap[seg]);
            run_random(SEG_ITEMS, (seg_cap[seg] > N_ENTRIES) ? N_ENTRIES : seg_cap[seg]);
        end

        // A often used entry outlasts newer ones with fewer uses
        write_capacity(5'd2);
        send_request(OP_PUT, 32'h0BAD_F00D, 32'hFEED_0001);
        repeat (4) send_request(OP_GET, 32'h0BAD_F00D, 32'h0);
        send_request(OP_PUT, 32'h7777_0001, 32'hFEED_0002);
        repeat (2) send_request(OP_GET, 32'h7777_0001, 32'h0);
        send_request(OP_PUT, 32'h7777_0002, 32'hFEED_0003);
        send_request(OP_GET, 32'h7777_0001, 32'h0);
        send_request(OP_GET, 32'h0BAD_F00D, 32'h0);

        drain();
        repeat (SETTLE_CYC) @(posedge i_clk);

        $display("run covered %0d requests: %0d hits, %0d evictions, %0d saturated touches",
                 cache_model.requests, cache_model.hits, cache_model.evictions,
                 cache_model.saturated);
        $display("capacities 0 to 31 incl. shrink below occupancy, both stall patterns, no stall");
        if (cache_model.errors == 0) begin
            $display("lfu_cache_lru_tiebreak_top_tb: done, clean");
        end else begin
            $display("lfu_cache_lru_tiebreak_top_tb: done, errors");
        end
        $finish;
    end

endmodule
